// File: sv/nonlinear_capacitor_filter_cascade_macros.svh
// assertion helpers used by the checker
`ifndef NONLINEAR_CAPACITOR_FILTER_CASCADE_MACROS_SVH
`define NONLINEAR_CAPACITOR_FILTER_CASCADE_MACROS_SVH

// consequent must hold in the same cycle
`define NCFC_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the following cycle
`define NCFC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/ncfc_pkg.sv
`default_nettype none
package ncfc_pkg;

    localparam int CHANNELS    = 2;
    localparam int STAGE_SLOTS = 6;
    localparam int MEM_DEPTH   = CHANNELS * 2 * STAGE_SLOTS;
    localparam int MEM_AW      = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    localparam int ONE_Q23     = 1 << 23;
    localparam int HALF_Q23    = 1 << 22;
    localparam int STAGE_LIMIT = 100 * ONE_Q23;

    // shared multiplier operand widths
    localparam int MAC_AW = 35;
    localparam int MAC_BW = 26;
    localparam int MAC_PW = 61;

    // shared divider widths
    localparam int DIV_NW = 50;
    localparam int DIV_DW = 26;
    localparam int DIV_QW = 25;

    // register indexes
    localparam logic [1:0] REG_LOWPASS  = 2'd0;
    localparam logic [1:0] REG_HIGHPASS = 2'd1;
    localparam logic [1:0] REG_NONLIN   = 2'd2;
    localparam logic [1:0] REG_DRYWET   = 2'd3;

    typedef struct packed {
        logic                     start;
        logic signed [MAC_AW-1:0] a;
        logic signed [MAC_BW-1:0] b;
        logic signed [MAC_PW-1:0] c;
    } mac_req_t;

    typedef struct packed {
        logic                     done;
        logic signed [MAC_PW-1:0] res;
    } mac_rsp_t;

    typedef struct packed {
        logic              start;
        logic [DIV_NW-1:0] num;
        logic [DIV_DW-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DIV_QW-1:0] quo;
    } div_rsp_t;

    // floor((k * 2^23 + 32767) / 65535), full scale maps to exactly 2^23
    function automatic logic [23:0] knob_frac(input logic [15:0] k);
        logic [23:0] y;
        logic [7:0]  t;
        logic [16:0] r;
        y = {1'b0, k, 7'd0} + 24'd32767;
        t = y[23:16];
        r = {9'd0, t} + {1'b0, y[15:0]};
        return {1'b0, k, 7'd0} + 24'(t) + 24'(r >= 17'd65535);
    endfunction

endpackage
`default_nettype wire

// File: sv/nonlinear_capacitor_filter_cascade.sv
// channel   dir  handshake              payload
// s_        in   s_tvalid / s_tready    s_tdata: sample_in; s_tuser: channel, block_start
// m_        out  m_tvalid / m_tready    m_tdata: sample_out
// cfg_      in   cfg_valid / cfg_ready  cfg_index, cfg_data (knob registers)
//
// the divider (five divisions, or eight with a block start) and the cube root
// on the shared multiplier (17 steps of two products) set how long a word takes
// from input to output.
// aresetn is synchronous; it clears all filter memories, smoothers and rates.
// the result sits in an output register, so a stalled m_tready holds only
// the finished word while the next sample is taken.
`default_nettype none
module nonlinear_capacitor_filter_cascade (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output      logic        s_tready,
    input  wire logic [23:0] s_tdata,   // [23:0] sample_in
    input  wire logic [1:0]  s_tuser,   // [0] channel, [1] block_start
    output      logic        m_tvalid,
    input  wire logic        m_tready,
    output      logic [23:0] m_tdata,   // [23:0] sample_out
    input  wire logic        cfg_valid,
    output      logic        cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);
    import ncfc_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_TGT, S_RATE, S_CSQ, S_CCU, S_TRIM, S_QDIV, S_SMUL, S_SDIV,
        S_AMUL, S_STRD, S_STA, S_STB, S_WV, S_MXA, S_MXB, S_DONE
    } state_t;

    localparam logic [1:0] K_WET = 2'd2;
    localparam logic [DIV_NW-1:0] RATE_NUM = DIV_NW'(300) << 38;
    localparam logic [DIV_NW-1:0] TRIM_NUM = DIV_NW'(3) << 38;
    localparam logic signed [MAC_PW-1:0] LIM_P = MAC_PW'(STAGE_LIMIT);
    localparam logic signed [MAC_PW-1:0] LIM_N = -LIM_P;
    localparam logic signed [MAC_PW-1:0] Y_MAX = MAC_PW'(8388607);
    localparam logic signed [MAC_PW-1:0] Y_MIN = -MAC_PW'(8388608);
    localparam logic signed [MAC_PW-1:0] RND = MAC_PW'(HALF_Q23);

    // configuration
    logic [15:0] lp_knob_reg, hp_knob_reg, nl_knob_reg, dw_knob_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lp_knob_reg <= 16'hFFFF;
            hp_knob_reg <= 16'h0000;
            nl_knob_reg <= 16'h0000;
            dw_knob_reg <= 16'hFFFF;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_LOWPASS:  lp_knob_reg <= cfg_data;
                REG_HIGHPASS: hp_knob_reg <= cfg_data;
                REG_NONLIN:   nl_knob_reg <= cfg_data;
                REG_DRYWET:   dw_knob_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer state
    state_t                   state_reg;
    logic                     pend_reg;
    logic [1:0]               k_reg;
    logic [2:0]               j_reg;
    logic [4:0]               bit_reg;
    logic [16:0]              cb_reg;
    logic [2:0]               gear_reg;
    logic signed [23:0]       x_reg;
    logic                     ch_reg;
    logic [23:0]              t_reg;
    logic [23:0]              trim_reg;
    logic [24:0]              dscale_reg;
    logic [24:0]              lpa_reg, hpa_reg;
    logic signed [31:0]       v_reg;
    logic signed [31:0]       wv_reg;
    logic signed [31:0]       mem_rd_reg;
    logic [23:0]              y_reg;
    logic [23:0]              m_data_reg;
    logic                     m_valid_reg;
    logic [23:0]              smooth_reg  [3];
    logic [23:0]              applied_reg [3];
    logic [23:0]              rate_reg    [3];
    logic signed [31:0]       mem_reg     [MEM_DEPTH];

    mac_req_t mac_req;
    mac_rsp_t mac_rsp;
    div_req_t div_req;
    div_rsp_t div_rsp;

    ncfc_mac u_mac (.aclk(aclk), .aresetn(aresetn), .req(mac_req), .rsp(mac_rsp));
    ncfc_div u_div (.aclk(aclk), .aresetn(aresetn), .req(div_req), .rsp(div_rsp));

    // derived values
    logic [23:0]              f_lp, f_hp, f_nl, f_wet, f_sel, nl_diff;
    logic [25:0]              nl;
    logic [16:0]              t_cb;
    logic [23:0]              mag;
    logic [23:0]              d_abs;
    logic [24:0]              rate_den;
    logic [24:0]              sm_den;
    logic [24:0]              amt;
    logic signed [25:0]       amt_inv;
    logic [23:0]              sm_cur, sm_tgt, sm_raw, sm_fix;
    logic [24:0]              dsc_calc;
    logic signed [MAC_PW-1:0] res_sh;
    logic signed [31:0]       st_sat;
    logic [23:0]              y_sat;
    logic [2:0]               gear_nx;
    logic [2:0]               gear_m3;
    logic [2:0]               slot;
    logic [MEM_AW-1:0]        mem_idx;
    logic                     mac_go;
    logic                     div_go;
    logic                     out_load;

    assign f_lp    = knob_frac(lp_knob_reg);
    assign f_hp    = knob_frac(hp_knob_reg);
    assign f_nl    = knob_frac(nl_knob_reg);
    assign f_wet   = knob_frac(dw_knob_reg);
    assign f_sel   = k_reg[0] ? f_hp : f_lp;
    assign nl_diff = 24'(ONE_Q23) - f_nl;
    // one plus six times the complement
    assign nl      = 26'(ONE_Q23) + {nl_diff, 2'b00} + {1'b0, nl_diff, 1'b0};
    assign t_cb    = cb_reg | (17'd1 << bit_reg);
    assign mag     = x_reg[23] ? (~x_reg + 24'd1) : x_reg;

    assign d_abs    = (applied_reg[k_reg] > t_reg) ? (applied_reg[k_reg] - t_reg)
                                                   : (t_reg - applied_reg[k_reg]);
    assign rate_den = {1'b0, d_abs} + 25'(ONE_Q23);
    assign sm_den   = {1'b0, rate_reg[k_reg]} + 25'(1 << 15);

    assign amt     = j_reg[0] ? lpa_reg : hpa_reg;
    assign amt_inv = $signed(26'(ONE_Q23)) - $signed({1'b0, amt});

    assign sm_cur = smooth_reg[k_reg];
    assign sm_tgt = applied_reg[k_reg];
    assign sm_raw = div_rsp.quo[23:0];
    // a stalled smoother still creeps one step toward its target
    always_comb begin
        sm_fix = sm_raw;
        if (sm_raw == sm_cur && sm_cur != sm_tgt) begin
            sm_fix = (sm_tgt > sm_cur) ? sm_cur + 24'd1 : sm_cur - 24'd1;
        end
    end

    always_comb begin
        if (x_reg[23]) begin
            dsc_calc = 25'(ONE_Q23) + {1'b0, div_rsp.quo[23:0]};
        end else if (div_rsp.quo[23:0] <= 24'(ONE_Q23)) begin
            dsc_calc = 25'(ONE_Q23) - {1'b0, div_rsp.quo[23:0]};
        end else begin
            dsc_calc = {1'b0, div_rsp.quo[23:0]} - 25'(ONE_Q23);
        end
    end

    assign res_sh = mac_rsp.res >>> 23;

    always_comb begin
        if (res_sh > LIM_P) begin
            st_sat = 32'(LIM_P);
        end else if (res_sh < LIM_N) begin
            st_sat = 32'(LIM_N);
        end else begin
            st_sat = 32'(res_sh);
        end
        if (res_sh > Y_MAX) begin
            y_sat = 24'(Y_MAX);
        end else if (res_sh < Y_MIN) begin
            y_sat = 24'(Y_MIN);
        end else begin
            y_sat = 24'(res_sh);
        end
    end

    // gear slots: A, then B or C by parity, then D..F by count mod 3
    assign gear_nx = (gear_reg == 3'd5) ? 3'd0 : gear_reg + 3'd1;
    assign gear_m3 = (gear_reg >= 3'd3) ? gear_reg - 3'd3 : gear_reg;

    always_comb begin
        case (j_reg[2:1])
            2'd0:    slot = 3'd0;
            2'd1:    slot = 3'd1 + {2'd0, gear_reg[0]};
            default: slot = 3'd3 + gear_m3;
        endcase
    end

    assign mem_idx = MEM_AW'((CHANNELS > 1) ? ch_reg : 1'b0) * MEM_AW'(2 * STAGE_SLOTS)
                   + (j_reg[0] ? MEM_AW'(STAGE_SLOTS) : MEM_AW'(0)) + MEM_AW'(slot);

    // finished word moves into the output register
    assign out_load = (state_reg == S_DONE) && (!m_valid_reg || m_tready);

    // operand selection for the shared units
    always_comb begin
        mac_go    = 1'b0;
        mac_req.a = '0;
        mac_req.b = '0;
        mac_req.c = '0;
        div_go    = 1'b0;
        div_req.num = '0;
        div_req.den = '0;
        case (state_reg)
            S_TGT: begin
                mac_go    = (k_reg != K_WET);
                mac_req.a = MAC_AW'(f_sel);
                mac_req.b = MAC_BW'(f_sel);
                mac_req.c = RND;
            end
            S_RATE: begin
                div_go      = 1'b1;
                div_req.num = RATE_NUM + DIV_NW'(rate_den >> 1);
                div_req.den = DIV_DW'(rate_den);
            end
            S_CSQ: begin
                mac_go    = 1'b1;
                mac_req.a = MAC_AW'(t_cb);
                mac_req.b = MAC_BW'(t_cb);
            end
            S_CCU: begin
                mac_go    = 1'b1;
                mac_req.a = MAC_AW'(mac_rsp.res[33:0]);
                mac_req.b = MAC_BW'(t_cb);
            end
            S_TRIM: begin
                div_go      = 1'b1;
                div_req.num = TRIM_NUM + DIV_NW'(cb_reg >> 1);
                div_req.den = DIV_DW'(cb_reg);
            end
            S_QDIV: begin
                div_go      = 1'b1;
                div_req.num = DIV_NW'({mag, 23'd0}) + DIV_NW'(nl >> 1);
                div_req.den = nl;
            end
            S_SMUL: begin
                mac_go    = 1'b1;
                mac_req.a = MAC_AW'(sm_cur);
                mac_req.b = MAC_BW'(rate_reg[k_reg]);
                mac_req.c = MAC_PW'({sm_tgt, 15'd0});
            end
            S_SDIV: begin
                div_go      = 1'b1;
                div_req.num = DIV_NW'(mac_rsp.res[47:0]) + DIV_NW'(sm_den >> 1);
                div_req.den = DIV_DW'(sm_den);
            end
            S_AMUL: begin
                mac_go    = 1'b1;
                mac_req.a = MAC_AW'(sm_cur);
                mac_req.b = MAC_BW'(dscale_reg);
                mac_req.c = RND;
            end
            S_STA: begin
                mac_go    = 1'b1;
                mac_req.a = MAC_AW'(mem_rd_reg);
                mac_req.b = amt_inv;
                mac_req.c = RND;
            end
            S_STB: begin
                mac_go    = 1'b1;
                mac_req.a = MAC_AW'(v_reg);
                mac_req.b = MAC_BW'(amt);
                mac_req.c = mac_rsp.res;
            end
            S_WV: begin
                mac_go    = 1'b1;
                mac_req.a = MAC_AW'(v_reg);
                mac_req.b = MAC_BW'(trim_reg);
                mac_req.c = RND;
            end
            S_MXA: begin
                mac_go    = 1'b1;
                mac_req.a = MAC_AW'(x_reg);
                mac_req.b = MAC_BW'(25'(ONE_Q23) - {1'b0, smooth_reg[K_WET]});
                mac_req.c = RND;
            end
            S_MXB: begin
                mac_go    = 1'b1;
                mac_req.a = MAC_AW'(wv_reg);
                mac_req.b = MAC_BW'(smooth_reg[K_WET]);
                mac_req.c = mac_rsp.res;
            end
            default: ;
        endcase
        mac_req.start = mac_go && !pend_reg;
        div_req.start = div_go && !pend_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            pend_reg    <= 1'b0;
            k_reg       <= 2'd0;
            j_reg       <= 3'd0;
            bit_reg     <= 5'd16;
            cb_reg      <= '0;
            gear_reg    <= 3'd0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                smooth_reg[i]  <= '0;
                applied_reg[i] <= '0;
                rate_reg[i]    <= '0;
            end
            for (int i = 0; i < MEM_DEPTH; i++) begin
                mem_reg[i] <= '0;
            end
        end else begin
            if (mac_req.start || div_req.start) begin
                pend_reg <= 1'b1;
            end else if (mac_rsp.done || div_rsp.done) begin
                pend_reg <= 1'b0;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        x_reg   <= s_tdata;
                        v_reg   <= 32'(signed'(s_tdata));
                        ch_reg  <= s_tuser[0];
                        k_reg   <= 2'd0;
                        cb_reg  <= '0;
                        bit_reg <= 5'd16;
                        state_reg <= s_tuser[1] ? S_TGT : S_CSQ;
                    end
                end
                S_TGT: begin
                    if (k_reg == K_WET) begin
                        t_reg     <= f_wet;
                        state_reg <= S_RATE;
                    end else if (mac_rsp.done) begin
                        t_reg     <= mac_rsp.res[46:23];
                        state_reg <= S_RATE;
                    end
                end
                S_RATE: begin
                    if (div_rsp.done) begin
                        rate_reg[k_reg]    <= div_rsp.quo[23:0];
                        applied_reg[k_reg] <= t_reg;
                        if (k_reg == K_WET) begin
                            k_reg     <= 2'd0;
                            state_reg <= S_CSQ;
                        end else begin
                            k_reg     <= k_reg + 2'd1;
                            state_reg <= S_TGT;
                        end
                    end
                end
                S_CSQ: begin
                    if (mac_rsp.done) begin
                        state_reg <= S_CCU;
                    end
                end
                S_CCU: begin
                    if (mac_rsp.done) begin
                        if (mac_rsp.res[50:0] <= {nl, 25'd0}) begin
                            cb_reg <= t_cb;
                        end
                        if (bit_reg == 5'd0) begin
                            state_reg <= S_TRIM;
                        end else begin
                            bit_reg   <= bit_reg - 5'd1;
                            state_reg <= S_CSQ;
                        end
                    end
                end
                S_TRIM: begin
                    if (div_rsp.done) begin
                        trim_reg  <= div_rsp.quo[23:0];
                        state_reg <= S_QDIV;
                    end
                end
                S_QDIV: begin
                    if (div_rsp.done) begin
                        dscale_reg <= dsc_calc;
                        k_reg      <= 2'd0;
                        state_reg  <= S_SMUL;
                    end
                end
                S_SMUL: begin
                    if (mac_rsp.done) begin
                        state_reg <= S_SDIV;
                    end
                end
                S_SDIV: begin
                    if (div_rsp.done) begin
                        smooth_reg[k_reg] <= sm_fix;
                        if (k_reg == K_WET) begin
                            k_reg     <= 2'd0;
                            state_reg <= S_AMUL;
                        end else begin
                            k_reg     <= k_reg + 2'd1;
                            state_reg <= S_SMUL;
                        end
                    end
                end
                S_AMUL: begin
                    if (mac_rsp.done) begin
                        if (k_reg == 2'd0) begin
                            lpa_reg <= mac_rsp.res[47:23];
                            k_reg   <= 2'd1;
                        end else begin
                            hpa_reg   <= mac_rsp.res[47:23];
                            gear_reg  <= gear_nx;
                            j_reg     <= 3'd0;
                            state_reg <= S_STRD;
                        end
                    end
                end
                S_STRD: begin
                    mem_rd_reg <= mem_reg[mem_idx];
                    state_reg  <= S_STA;
                end
                S_STA: begin
                    if (mac_rsp.done) begin
                        state_reg <= S_STB;
                    end
                end
                S_STB: begin
                    if (mac_rsp.done) begin
                        mem_reg[mem_idx] <= st_sat;
                        // highpass takes the difference, lowpass passes its memory
                        v_reg <= j_reg[0] ? st_sat : v_reg - st_sat;
                        if (j_reg == 3'd5) begin
                            state_reg <= S_WV;
                        end else begin
                            j_reg     <= j_reg + 3'd1;
                            state_reg <= S_STRD;
                        end
                    end
                end
                S_WV: begin
                    if (mac_rsp.done) begin
                        wv_reg    <= 32'(res_sh);
                        state_reg <= S_MXA;
                    end
                end
                S_MXA: begin
                    if (mac_rsp.done) begin
                        state_reg <= S_MXB;
                    end
                end
                S_MXB: begin
                    if (mac_rsp.done) begin
                        y_reg     <= y_sat;
                        state_reg <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_load) begin
                        m_data_reg <= y_reg;
                        state_reg  <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule
`default_nettype wire

// File: sv/ncfc_mac.sv
`default_nettype none
module ncfc_mac (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire ncfc_pkg::mac_req_t req,
    output ncfc_pkg::mac_rsp_t     rsp
);
    import ncfc_pkg::*;

    logic signed [MAC_PW-1:0] prod_reg;
    logic signed [MAC_PW-1:0] add_reg;
    logic signed [MAC_PW-1:0] res_reg;
    logic                     busy_reg;
    logic                     done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= req.start;
            done_reg <= busy_reg;
        end
    end

    // product registered before the add
    always_ff @(posedge aclk) begin
        if (req.start) begin
            prod_reg <= req.a * req.b;
            add_reg  <= req.c;
        end
        if (busy_reg) begin
            res_reg <= prod_reg + add_reg;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.res  = res_reg;

endmodule
`default_nettype wire

// File: sv/ncfc_div.sv
`default_nettype none
module ncfc_div (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire ncfc_pkg::div_req_t req,
    output ncfc_pkg::div_rsp_t     rsp
);
    import ncfc_pkg::*;

    logic [DIV_DW-1:0] rem_reg;
    logic [DIV_QW-1:0] lo_reg;
    logic [DIV_QW-1:0] quo_reg;
    logic [4:0]        cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [DIV_DW-1:0] req_den_reg;
    logic [DIV_DW:0]   shifted;
    logic              fits;

    assign shifted = {rem_reg, lo_reg[DIV_QW-1]};
    assign fits    = shifted >= {1'b0, req_den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == 5'd0) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // restoring division, one quotient bit a cycle
    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg     <= DIV_DW'(req.num[DIV_NW-1:DIV_QW]);
            lo_reg      <= req.num[DIV_QW-1:0];
            req_den_reg <= req.den;
            quo_reg     <= '0;
            cnt_reg     <= 5'(DIV_QW - 1);
        end else if (busy_reg) begin
            if (fits) begin
                rem_reg <= DIV_DW'(shifted - {1'b0, req_den_reg});
            end else begin
                rem_reg <= DIV_DW'(shifted);
            end
            quo_reg <= {quo_reg[DIV_QW-2:0], fits};
            lo_reg  <= {lo_reg[DIV_QW-2:0], 1'b0};
            cnt_reg <= cnt_reg - 5'd1;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

endmodule
`default_nettype wire

// File: sv/ncfc_checker.sv
`default_nettype none
`include "nonlinear_capacitor_filter_cascade_macros.svh"
module ncfc_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata
);
    // a stalled word keeps its value
    `NCFC_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output word changed while stalled")
    // one sample at a time: busy right after taking a word
    `NCFC_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready, "input taken while a sample is in work")
    // no result can appear in the cycle right after a sample is taken
    `NCFC_ASSERT_NEXT(a_no_instant_result, aclk, aresetn, s_tvalid && s_tready && !m_tvalid, !m_tvalid, "result appeared too early")
    // out of reset the output is not valid
    `NCFC_ASSERT_NOW(a_idle_after_reset, aclk, aresetn, $rose(aresetn), !m_tvalid, "output valid out of reset")

endmodule

bind nonlinear_capacitor_filter_cascade ncfc_checker u_ncfc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire

// File: bench/nonlinear_capacitor_filter_cascade_tb.sv
`timescale 1ns / 1ps
module nonlinear_capacitor_filter_cascade_tb;
    import ncfc_pkg::*;

    localparam longint Q23 = 64'sd1 << 23;
    localparam longint LIMIT = 64'sd100 * Q23;

    class filter_scoreboard;
        logic [15:0] knob [4];
        longint mem [MEM_DEPTH];
        longint lp_s, hp_s, wet_s, lp_t, hp_t, wet_t;
        longint rate [3];
        int gear;
        logic [23:0] expected_q [$];
        int errors;

        function new();
            knob[REG_LOWPASS] = 16'hFFFF;
            knob[REG_HIGHPASS] = 16'h0000;
            knob[REG_NONLIN] = 16'h0000;
            knob[REG_DRYWET] = 16'hFFFF;
            foreach (mem[i]) mem[i] = 0;
            lp_s = 0; hp_s = 0; wet_s = 0;
            lp_t = 0; hp_t = 0; wet_t = 0;
            foreach (rate[i]) rate[i] = 0;
            gear = 0;
            errors = 0;
        endfunction

        // floor((a + 2^22) / 2^23)
        function longint rnd(longint a);
            return (a + (Q23 >>> 1)) >>> 23;
        endfunction

        function longint frac(logic [15:0] k);
            return ((longint'(k) << 23) + 32767) / 65535;
        endfunction

        function longint square(logic [15:0] k);
            longint f;
            f = frac(k);
            return (f * f + (Q23 >>> 1)) >>> 23;
        endfunction

        function longint glide_rate(longint applied, longint target);
            longint den;
            den = (applied > target ? applied - target : target - applied) + Q23;
            return ((64'sd300 << 38) + den / 2) / den;
        endfunction

        function longint glide(longint s, longint target, longint r);
            longint den, n;
            den = r + (64'sd1 << 15);
            n = (s * r + (target << 15) + den / 2) / den;
            if (n == s && s != target) n = target > s ? s + 1 : s - 1;
            return n;
        endfunction

        function longint cbrt_q16(longint nl);
            longint goal, c, t;
            goal = nl << 25;
            c = 0;
            for (int b = 16; b >= 0; b--) begin
                t = c | (64'sd1 << b);
                if (t * t * t <= goal) c = t;
            end
            return c;
        endfunction

        function longint run_stage(int idx, longint v, longint amount);
            longint m;
            m = rnd(mem[idx] * (Q23 - amount) + v * amount);
            if (m > LIMIT) m = LIMIT;
            if (m < -LIMIT) m = -LIMIT;
            mem[idx] = m;
            return m;
        endfunction

        function void write_knob(logic [1:0] idx, logic [15:0] data);
            knob[idx] = data;
        endfunction

        function void note_sample(logic [23:0] d, logic [1:0] u);
            longint x, nl, c, trim, mag, q, dsc, lpa, hpa, v, wv, r, lt, ht, wt;
            int base, slot [3];
            x = longint'(signed'(d));
            base = int'(u[0]) * 2 * STAGE_SLOTS;
            if (u[1]) begin
                lt = square(knob[REG_LOWPASS]);
                ht = square(knob[REG_HIGHPASS]);
                wt = frac(knob[REG_DRYWET]);
                rate[0] = glide_rate(lp_t, lt);
                rate[1] = glide_rate(hp_t, ht);
                rate[2] = glide_rate(wet_t, wt);
                lp_t = lt; hp_t = ht; wet_t = wt;
            end
            nl = Q23 + 6 * (Q23 - frac(knob[REG_NONLIN]));
            c = cbrt_q16(nl);
            trim = ((64'sd3 << 38) + c / 2) / c;
            mag = x < 0 ? -x : x;
            q = ((mag << 23) + nl / 2) / nl;
            dsc = Q23 - (x < 0 ? -q : q);
            if (dsc < 0) dsc = -dsc;
            lp_s = glide(lp_s, lp_t, rate[0]);
            hp_s = glide(hp_s, hp_t, rate[1]);
            wet_s = glide(wet_s, wet_t, rate[2]);
            lpa = rnd(lp_s * dsc);
            hpa = rnd(hp_s * dsc);
            gear = (gear + 1) % 6;
            slot[0] = 0;
            slot[1] = 1 + (gear & 1);
            slot[2] = 3 + gear % 3;
            v = x;
            for (int i = 0; i < 3; i++) begin
                v = v - run_stage(base + slot[i], v, hpa);
                v = run_stage(base + STAGE_SLOTS + slot[i], v, lpa);
            end
            wv = rnd(v * trim);
            r = rnd(x * (Q23 - wet_s) + wv * wet_s);
            if (r > 64'sd8388607) r = 64'sd8388607;
            if (r < -64'sd8388608) r = -64'sd8388608;
            expected_q.push_back(r[23:0]);
        endfunction

        function void check_sample(logic [23:0] d);
            logic [23:0] want;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected output word %h", d);
                return;
            end
            want = expected_q.pop_front();
            if (want !== d) begin
                errors++;
                if (errors <= 10)
                    $display("sample_out mismatch: expected %h actual %h", want, d);
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    filter_scoreboard sb = new();
    bit quiet = 0;
    bit hold_req = 0;

    always #5 aclk = ~aclk;

    nonlinear_capacitor_filter_cascade u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 4);
        return $urandom_range(20, 200);
    endfunction

    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) sb.write_knob(cfg_index, cfg_data);
            if (s_tvalid && s_tready) sb.note_sample(s_tdata, s_tuser);
            if (m_tvalid && m_tready) sb.check_sample(m_tdata);
        end
    end

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        int stall;
        stall = 0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (3000) @(posedge aclk);
                hold_req = 0;
            end else if (stall > 0) begin
                m_tready <= 1'b0;
                stall--;
            end else begin
                m_tready <= 1'b1;
                stall = pick_gap();
            end
        end
    end

    task automatic send_word(logic [23:0] d, logic [1:0] u);
        int g;
        s_tvalid <= 1'b1;
        s_tdata <= d;
        s_tuser <= u;
        do @(posedge aclk); while (!s_tready);
        g = pick_gap();
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
    endtask

    // advance the clock before checking the queue so the last accepted word is already noted
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.expected_q.size() != 0);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_knobs(logic [15:0] lp, logic [15:0] hp, logic [15:0] nl,
                               logic [15:0] dw);
        logic [15:0] v [4];
        v[REG_LOWPASS] = lp; v[REG_HIGHPASS] = hp; v[REG_NONLIN] = nl; v[REG_DRYWET] = dw;
        for (int i = 0; i < 4; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= 2'(i);
            cfg_data <= v[i];
            do @(posedge aclk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [23:0] rand_sample();
        case ($urandom_range(0, 5))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return 24'(signed'($urandom_range(0, 2000)) - 1000);
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] rand_knob();
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic run_blocks(int n);
        int left;
        left = 0;
        for (int i = 0; i < n; i++) begin
            logic [1:0] u;
            u[0] = $urandom_range(0, 1);
            if (left == 0) begin
                u[1] = 1'b1;
                left = $urandom_range(4, 48);
            end else begin
                u[1] = ($urandom_range(0, 49) == 0);
                left--;
            end
            send_word(rand_sample(), u);
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // before any block start the targets are still zero
        send_word(24'h7FFFFF, 2'b00);
        send_word(24'h800000, 2'b01);
        send_word(24'h000000, 2'b00);
        send_word(24'h000001, 2'b01);
        send_word(24'hFFFFFF, 2'b10);
        for (int i = 0; i < 7; i++) send_word(i[0] ? 24'h7FFFFF : 24'h800000, 2'(i & 1));
        drain();
        write_knobs(16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000);
        send_word(24'h400000, 2'b10);
        send_word(24'h800000, 2'b11);
        for (int i = 0; i < 6; i++) send_word(24'h7FFFFF, 2'b00);
        drain();
        write_knobs(16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF);
        send_word(24'h7FFFFF, 2'b11);
        // nonlinearity moves without a block start
        drain();
        write_knobs(16'hFFFF, 16'h0000, 16'h8000, 16'hFFFF);
        for (int i = 0; i < 4; i++) send_word(rand_sample(), 2'(i & 1));
        drain();

        for (int ph = 0; ph < 7; ph++) begin
            case (ph)
                0: write_knobs(16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF);
                1: write_knobs(16'h0000, 16'h0000, 16'hFFFF, 16'h0000);
                default: write_knobs(rand_knob(), rand_knob(), rand_knob(), rand_knob());
            endcase
            quiet = (ph == 3);
            if (ph == 2) hold_req = 1;
            run_blocks(100);
            drain();
        end
        quiet = 0;

        if (sb.expected_q.size() != 0) sb.errors++;
        if (sb.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #40ms;
        $display("FAILURE");
        $finish;
    end
endmodule
